>>> rtl/ebrm_pkg.sv
// Package for the eight-bit register machine core: sizes, codes and shared types.
// No dependencies; used by the top level and ebrm_regfile.
`default_nettype none

package ebrm_pkg;

	localparam int DATA_BYTES = 256;
	localparam int DADDR_W    = $clog2(DATA_BYTES);
	localparam int REG_COUNT  = 16;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);

	localparam logic [15:0] PC_STEP = 16'd2;

	typedef enum logic [1:0] {
		KIND_EXEC    = 2'd0,
		KIND_SET_REG = 2'd1,
		KIND_SET_MEM = 2'd2,
		KIND_GET_MEM = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_INC   = 4'd3,
		OP_AND   = 4'd4,
		OP_OR    = 4'd5,
		OP_NOT   = 4'd6,
		OP_XOR   = 4'd7,
		OP_LOAD  = 4'd8,
		OP_STORE = 4'd9,
		OP_JMP   = 4'd10,
		OP_BEQZ  = 4'd11,
		OP_HALT  = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_ARITH = 3'd1,
		CLS_LOGIC = 3'd2,
		CLS_DATA  = 3'd3,
		CLS_CTRL  = 3'd4,
		CLS_HALT  = 3'd5
	} cls_t;

	// register file write port
	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] idx;
		logic [7:0]           data;
	} rf_wr_t;

endpackage

`default_nettype wire

>>> rtl/ebrm_cmd_if.sv
// Command channel of the register machine core: one instruction or host access per item.
// Standalone valid/ready interface; no dependencies.
`default_nettype none

interface ebrm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] instruction_word;
	logic [7:0]  target_index;
	logic [7:0]  load_value;

	modport source (output valid, opcode, instruction_word, target_index, load_value,
		input ready);
	modport sink (input valid, opcode, instruction_word, target_index, load_value,
		output ready);
endinterface

`default_nettype wire

>>> rtl/ebrm_rsp_if.sv
// Result channel of the register machine core: one result item per command item.
// Standalone valid/ready interface; no dependencies.
`default_nettype none

interface ebrm_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] next_pc;
	logic        halted;
	logic        reg_write_valid;
	logic [3:0]  reg_write_index;
	logic [7:0]  reg_write_value;
	logic        mem_write_valid;
	logic [7:0]  mem_address;
	logic [7:0]  mem_value;
	logic [2:0]  instr_class;

	modport source (output valid, next_pc, halted, reg_write_valid, reg_write_index,
		reg_write_value, mem_write_valid, mem_address, mem_value, instr_class,
		input ready);
	modport sink (input valid, next_pc, halted, reg_write_valid, reg_write_index,
		reg_write_value, mem_write_valid, mem_address, mem_value, instr_class,
		output ready);
endinterface

`default_nettype wire

>>> rtl/eight_bit_register_machine_core_top.sv
// Top level of the eight-bit register machine core: pipeline, data memory, PC and halt.
// Depends on ebrm_pkg, ebrm_cmd_if, ebrm_rsp_if and ebrm_regfile.
`default_nettype none

// Executes one 16-bit instruction, or one host register/memory access, per item and returns
// one result per item. Throughput is one item per clock unless rsp.ready back-pressure stalls
// the pipeline; an item passes register file read, execute with data memory access and the
// output register in turn. The register file and the data memory both have a registered read;
// operands are forwarded from the two most recent register writes so that dependent
// instructions can follow each other without bubbles. Register file and data memory read as
// zero after reset through per-entry valid bits, so no clearing pass is needed. Only reset
// leaves the halted state.
module eight_bit_register_machine_core_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ebrm_cmd_if.sink   cmd,
	ebrm_rsp_if.source rsp
);

	localparam int AW = ebrm_pkg::DADDR_W;
	localparam int IW = ebrm_pkg::REG_IDX_W;

	// handshake and stage control
	logic accept;
	logic s2_rdy;
	logic adv_s1;
	logic adv_out;
	logic v_s1;
	logic v_s2;
	logic v_out_q;

	// architectural state
	logic [15:0] pc_q;
	logic        halt_q;

	// stage 1
	ebrm_pkg::kind_t kind_s1;
	logic [15:0]     word_s1;
	logic [7:0]      tgt_s1;
	logic [7:0]      val_s1;
	logic [IW-1:0]   yidx_s1;

	// operand read select at accept
	logic [IW-1:0] rd_idx_y;

	// register file
	ebrm_pkg::rf_wr_t rf_wr;
	logic [7:0]       rx_raw;
	logic [7:0]       ry_raw;

	// last register write, kept for forwarding
	logic          wb_v_q;
	logic [IW-1:0] wb_idx_q;
	logic [7:0]    wb_data_q;

	// stage 1 decode and execute
	ebrm_pkg::op_t  op;
	logic [IW-1:0]  a_idx;
	logic [IW-1:0]  b_idx;
	logic [3:0]     c_off;
	logic [7:0]     rx;
	logic [7:0]     ry;
	logic [15:0]    prod;
	logic [7:0]     ea;
	logic [15:0]    pc_inc;
	logic [15:0]    npc;
	logic           halt_n;
	logic           rw_v;
	logic [IW-1:0]  rw_i;
	logic [7:0]     rw_d;
	logic           ld;
	logic           mw_v;
	logic           mrd;
	logic [AW-1:0]  m_a;
	logic [7:0]     m_d;
	ebrm_pkg::cls_t cls;

	// stage 2
	logic           rw_v_s2;
	logic [IW-1:0]  rw_i_s2;
	logic [7:0]     rw_d_s2;
	logic           ld_s2;
	logic           mw_v_s2;
	logic           mrd_s2;
	logic [AW-1:0]  ma_s2;
	logic [7:0]     md_s2;
	ebrm_pkg::cls_t cls_s2;
	logic [15:0]    pc_s2;
	logic           halt_s2;
	logic [7:0]     dm_raw_s2;
	logic           dm_vld_s2;
	logic [7:0]     dm_rd;
	logic [7:0]     s2_rf_data;

	// data memory
	logic [7:0]                      dmem [ebrm_pkg::DATA_BYTES];
	logic [ebrm_pkg::DATA_BYTES-1:0] dvld_q;

	// output register
	logic [15:0]    pc_q_out;
	logic           halt_out_q;
	logic           rw_v_q;
	logic [IW-1:0]  rw_i_q;
	logic [7:0]     rw_d_q;
	logic           mw_v_q;
	logic [AW-1:0]  ma_q;
	logic [7:0]     md_q;
	ebrm_pkg::cls_t cls_q;

	// ---------------- handshake ----------------
	assign adv_out   = v_s2 && (!v_out_q || rsp.ready);
	assign s2_rdy    = !v_s2 || !v_out_q || rsp.ready;
	assign adv_s1    = v_s1 && s2_rdy;
	assign cmd.ready = !v_s1 || s2_rdy;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			if (adv_out) begin
				v_out_q <= 1'b1;
			end else if (rsp.ready) begin
				v_out_q <= 1'b0;
			end
		end
	end

	// ---------------- accept / register read ----------------
	// second read port serves R[a] for INC, STORE, BEQZ and R[c] otherwise
	always_comb begin
		case (ebrm_pkg::op_t'(cmd.instruction_word[15:12]))
			ebrm_pkg::OP_INC, ebrm_pkg::OP_STORE, ebrm_pkg::OP_BEQZ:
				rd_idx_y = cmd.instruction_word[11:8];
			default:
				rd_idx_y = cmd.instruction_word[3:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= ebrm_pkg::kind_t'(cmd.opcode);
			word_s1 <= cmd.instruction_word;
			tgt_s1  <= cmd.target_index;
			val_s1  <= cmd.load_value;
			yidx_s1 <= rd_idx_y;
		end
	end

	ebrm_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx_x (cmd.instruction_word[7:4]),
		.rd_idx_y (rd_idx_y),
		.rd_x     (rx_raw),
		.rd_y     (ry_raw),
		.wr       (rf_wr)
	);

	// ---------------- stage 1: forward, execute ----------------
	assign op    = ebrm_pkg::op_t'(word_s1[15:12]);
	assign a_idx = word_s1[11:8];
	assign b_idx = word_s1[7:4];
	assign c_off = word_s1[3:0];

	assign dm_rd      = dm_vld_s2 ? dm_raw_s2 : 8'd0;
	assign s2_rf_data = ld_s2 ? dm_rd : rw_d_s2;

	// newest first: item in stage 2, then the write made at or after the read edge
	always_comb begin
		if (v_s2 && rw_v_s2 && (rw_i_s2 == b_idx)) begin
			rx = s2_rf_data;
		end else if (wb_v_q && (wb_idx_q == b_idx)) begin
			rx = wb_data_q;
		end else begin
			rx = rx_raw;
		end
		if (v_s2 && rw_v_s2 && (rw_i_s2 == yidx_s1)) begin
			ry = s2_rf_data;
		end else if (wb_v_q && (wb_idx_q == yidx_s1)) begin
			ry = wb_data_q;
		end else begin
			ry = ry_raw;
		end
	end

	assign prod   = 16'(rx) * 16'(ry);
	assign ea     = rx + {4'd0, c_off};
	assign pc_inc = pc_q + ebrm_pkg::PC_STEP;

	always_comb begin
		npc    = pc_q;
		halt_n = halt_q;
		rw_v   = 1'b0;
		rw_i   = '0;
		rw_d   = 8'd0;
		ld     = 1'b0;
		mw_v   = 1'b0;
		mrd    = 1'b0;
		m_a    = '0;
		m_d    = 8'd0;
		cls    = ebrm_pkg::CLS_NONE;
		unique case (kind_s1)
			ebrm_pkg::KIND_SET_REG: begin
				rw_v = 1'b1;
				rw_i = tgt_s1[IW-1:0];
				rw_d = val_s1;
			end
			ebrm_pkg::KIND_SET_MEM: begin
				mw_v = 1'b1;
				m_a  = AW'(tgt_s1 % ebrm_pkg::DATA_BYTES);
				m_d  = val_s1;
			end
			ebrm_pkg::KIND_GET_MEM: begin
				mrd = 1'b1;
				m_a = AW'(tgt_s1 % ebrm_pkg::DATA_BYTES);
			end
			ebrm_pkg::KIND_EXEC: begin
				if (!halt_q) begin
					npc = pc_inc;
					case (op)
						ebrm_pkg::OP_ADD: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = rx + ry;
							cls = ebrm_pkg::CLS_ARITH;
						end
						ebrm_pkg::OP_SUB: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = rx - ry;
							cls = ebrm_pkg::CLS_ARITH;
						end
						ebrm_pkg::OP_MUL: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = prod[7:0];
							cls = ebrm_pkg::CLS_ARITH;
						end
						ebrm_pkg::OP_INC: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = ry + 8'd1;
							cls = ebrm_pkg::CLS_ARITH;
						end
						ebrm_pkg::OP_AND: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = rx & ry;
							cls = ebrm_pkg::CLS_LOGIC;
						end
						ebrm_pkg::OP_OR: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = rx | ry;
							cls = ebrm_pkg::CLS_LOGIC;
						end
						ebrm_pkg::OP_NOT: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = ~rx;
							cls = ebrm_pkg::CLS_LOGIC;
						end
						ebrm_pkg::OP_XOR: begin
							rw_v = 1'b1; rw_i = a_idx; rw_d = rx ^ ry;
							cls = ebrm_pkg::CLS_LOGIC;
						end
						ebrm_pkg::OP_LOAD: begin
							rw_v = 1'b1; rw_i = a_idx; ld = 1'b1;
							mrd = 1'b1;
							m_a = AW'(ea % ebrm_pkg::DATA_BYTES);
							cls = ebrm_pkg::CLS_DATA;
						end
						ebrm_pkg::OP_STORE: begin
							mw_v = 1'b1;
							m_a  = AW'(ea % ebrm_pkg::DATA_BYTES);
							m_d  = ry;
							cls  = ebrm_pkg::CLS_DATA;
						end
						ebrm_pkg::OP_JMP: begin
							npc = pc_inc + {{7{word_s1[11]}}, word_s1[11:4], 1'b0};
							cls = ebrm_pkg::CLS_CTRL;
						end
						ebrm_pkg::OP_BEQZ: begin
							if (ry == 8'd0) begin
								npc = pc_inc + {{7{word_s1[7]}}, word_s1[7:0], 1'b0};
							end
							cls = ebrm_pkg::CLS_CTRL;
						end
						ebrm_pkg::OP_HALT: begin
							halt_n = 1'b1;
							cls    = ebrm_pkg::CLS_HALT;
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 16'd0;
			halt_q <= 1'b0;
			dvld_q <= '0;
		end else if (adv_s1) begin
			pc_q   <= npc;
			halt_q <= halt_n;
			if (mw_v) begin
				dvld_q[m_a] <= 1'b1;
			end
		end
	end

	// data memory: writes and reads both happen as the item leaves stage 1, in item order
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (mw_v) begin
				dmem[m_a] <= m_d;
			end
			dm_raw_s2 <= dmem[m_a];
			dm_vld_s2 <= dvld_q[m_a];
			rw_v_s2   <= rw_v;
			rw_i_s2   <= rw_i;
			rw_d_s2   <= rw_d;
			ld_s2     <= ld;
			mw_v_s2   <= mw_v;
			mrd_s2    <= mrd;
			ma_s2     <= m_a;
			md_s2     <= m_d;
			cls_s2    <= cls;
			pc_s2     <= npc;
			halt_s2   <= halt_n;
		end
	end

	// ---------------- stage 2: register write-back, output ----------------
	assign rf_wr.en   = adv_out && rw_v_s2;
	assign rf_wr.idx  = rw_i_s2;
	assign rf_wr.data = s2_rf_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_v_q <= 1'b0;
		end else if (rf_wr.en) begin
			wb_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_wr.en) begin
			wb_idx_q  <= rf_wr.idx;
			wb_data_q <= rf_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			pc_q_out   <= pc_s2;
			halt_out_q <= halt_s2;
			rw_v_q     <= rw_v_s2;
			rw_i_q     <= rw_i_s2;
			rw_d_q     <= rw_v_s2 ? s2_rf_data : 8'd0;
			mw_v_q     <= mw_v_s2;
			ma_q       <= ma_s2;
			md_q       <= mrd_s2 ? dm_rd : md_s2;
			cls_q      <= cls_s2;
		end
	end

	assign rsp.valid           = v_out_q;
	assign rsp.next_pc         = pc_q_out;
	assign rsp.halted          = halt_out_q;
	assign rsp.reg_write_valid = rw_v_q;
	assign rsp.reg_write_index = 4'(rw_i_q);
	assign rsp.reg_write_value = rw_d_q;
	assign rsp.mem_write_valid = mw_v_q;
	assign rsp.mem_address     = 8'(ma_q);
	assign rsp.mem_value       = md_q;
	assign rsp.instr_class     = cls_q;

endmodule

`default_nettype wire

>>> rtl/ebrm_regfile.sv
// Register file: 16 x 8, two registered read ports, one write port.
// Per-entry valid bits make unwritten registers read as zero after reset. Uses ebrm_pkg.
`default_nettype none

module ebrm_regfile (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [ebrm_pkg::REG_IDX_W-1:0] rd_idx_x,
	input  wire logic [ebrm_pkg::REG_IDX_W-1:0] rd_idx_y,
	output logic      [7:0]                     rd_x,
	output logic      [7:0]                     rd_y,
	input  wire ebrm_pkg::rf_wr_t               wr
);

	logic [7:0]                     mem [ebrm_pkg::REG_COUNT];
	logic [ebrm_pkg::REG_COUNT-1:0] vld_q;
	logic [7:0]                     x_raw_q;
	logic [7:0]                     y_raw_q;
	logic                           x_vld_q;
	logic                           y_vld_q;

	// read returns the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			x_raw_q <= mem[rd_idx_x];
			y_raw_q <= mem[rd_idx_y];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			x_vld_q <= 1'b0;
			y_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				x_vld_q <= vld_q[rd_idx_x];
				y_vld_q <= vld_q[rd_idx_y];
			end
		end
	end

	assign rd_x = x_vld_q ? x_raw_q : 8'd0;
	assign rd_y = y_vld_q ? y_raw_q : 8'd0;

endmodule

`default_nettype wire
